// ===== rtl/core/tsl_pkg.sv =====
// Shared types and constants for the TDMA slot lease table.
package tsl_pkg;

	localparam int SLOT_COUNT_DEF = 16;

	localparam logic [2:0] OP_CLEAR      = 3'd0;
	localparam logic [2:0] OP_TICK       = 3'd1;
	localparam logic [2:0] OP_JOIN       = 3'd2;
	localparam logic [2:0] OP_DATA       = 3'd3;
	localparam logic [2:0] OP_RESET      = 3'd4;
	localparam logic [2:0] OP_DISCONNECT = 3'd5;
	localparam logic [2:0] OP_KEEPALIVE  = 3'd6;

	localparam logic [1:0] KIND_SYNC  = 2'd0;
	localparam logic [1:0] KIND_JOIN  = 2'd1;
	localparam logic [1:0] KIND_RESET = 2'd2;

	localparam logic [1:0] CFG_SYNC_SLOT       = 2'd0;
	localparam logic [1:0] CFG_DEFAULT_LEASE   = 2'd1;
	localparam logic [1:0] CFG_LOW_POWER_LEASE = 2'd2;

	localparam logic [3:0]  SYNC_SLOT_RST       = 4'd0;
	localparam logic [15:0] DEFAULT_LEASE_RST   = 16'd10;
	localparam logic [31:0] LOW_POWER_LEASE_RST = 32'd3375;
	localparam logic [31:0] KEEPALIVE_FALLBACK  = 32'd6;

	typedef struct packed {
		logic [2:0]  operation;
		logic [3:0]  slot;
		logic [7:0]  requested_slot;
		logic        low_power;
		logic        is_echo;
		logic [31:0] keepalive_lease;
	} in_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  target_slot;
		logic [31:0] lease_left;
		logic [3:0]  next_free;
		logic        accepted;
		logic        echo_flag;
		logic        last;
	} out_t;

	typedef struct packed {
		logic [3:0]  sync_slot;
		logic [15:0] default_lease;
		logic [31:0] low_power_lease;
	} cfg_t;

endpackage

// ===== rtl/core/tdma_slot_lease_table.sv =====
// TDMA slot lease table: config registers, output register, sequencer and table.
// Frame tick: the slot is first reduced modulo SLOT_COUNT by repeated subtraction, then
//   the free-slot search reads one table entry per cycle and stops at the first free slot;
//   up to 2 result beats.
// Join: read, write, result beat; packets: read, write (+ a reset beat for a live non-echo reset); clear: no result.
// A new item is taken once the previous one has handed any last beat to the output register.
// Reset clears all leases and sets every refill to 10 through per-slot valid bits at once.
module tdma_slot_lease_table #(
	parameter int SLOT_COUNT = tsl_pkg::SLOT_COUNT_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  tsl_pkg::in_t  in_data,
	output logic          out_valid,
	input  logic          out_stall,
	output tsl_pkg::out_t out_data,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [1:0]    cfg_index,
	input  logic [31:0]   cfg_data
);

	localparam int IW = $clog2(SLOT_COUNT);

	tsl_pkg::cfg_t cfg_q;
	logic          out_valid_q;
	tsl_pkg::out_t out_q;
	logic          res_valid;
	tsl_pkg::out_t res;
	logic          res_free;
	logic          mem_clr;
	logic [31:0]   mem_clr_refill;
	logic          mem_we;
	logic [IW-1:0] mem_waddr;
	logic [31:0]   mem_wrefill;
	logic [31:0]   mem_wleft;
	logic [IW-1:0] mem_raddr;
	logic [31:0]   mem_rd_refill;
	logic [31:0]   mem_rd_left;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sync_slot       <= tsl_pkg::SYNC_SLOT_RST;
			cfg_q.default_lease   <= tsl_pkg::DEFAULT_LEASE_RST;
			cfg_q.low_power_lease <= tsl_pkg::LOW_POWER_LEASE_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				tsl_pkg::CFG_SYNC_SLOT: cfg_q.sync_slot <= cfg_data[3:0];
				tsl_pkg::CFG_DEFAULT_LEASE: cfg_q.default_lease <= cfg_data[15:0];
				tsl_pkg::CFG_LOW_POWER_LEASE: cfg_q.low_power_lease <= cfg_data;
				default: ;
			endcase
		end
	end

	assign res_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	tsl_ctrl #(
		.SLOT_COUNT(SLOT_COUNT)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.in_valid      (in_valid),
		.in_data       (in_data),
		.in_stall      (in_stall),
		.res_valid     (res_valid),
		.res           (res),
		.res_free      (res_free),
		.mem_clr       (mem_clr),
		.mem_clr_refill(mem_clr_refill),
		.mem_we        (mem_we),
		.mem_waddr     (mem_waddr),
		.mem_wrefill   (mem_wrefill),
		.mem_wleft     (mem_wleft),
		.mem_raddr     (mem_raddr),
		.mem_rd_refill (mem_rd_refill),
		.mem_rd_left   (mem_rd_left)
	);

	tsl_lease_mem #(
		.SLOT_COUNT(SLOT_COUNT)
	) u_mem (
		.clk       (clk),
		.arst_n    (arst_n),
		.clr       (mem_clr),
		.clr_refill(mem_clr_refill),
		.we        (mem_we),
		.waddr     (mem_waddr),
		.wrefill   (mem_wrefill),
		.wleft     (mem_wleft),
		.raddr     (mem_raddr),
		.rd_refill (mem_rd_refill),
		.rd_left   (mem_rd_left)
	);

endmodule

// ===== rtl/core/tsl_lease_mem.sv =====
// Per-slot lease and refill storage with valid bits and a clear that drops all valid bits at once.
module tsl_lease_mem #(
	parameter int SLOT_COUNT = tsl_pkg::SLOT_COUNT_DEF,
	localparam int IW = $clog2(SLOT_COUNT)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          clr,
	input  logic [31:0]   clr_refill,
	input  logic          we,
	input  logic [IW-1:0] waddr,
	input  logic [31:0]   wrefill,
	input  logic [31:0]   wleft,
	input  logic [IW-1:0] raddr,
	output logic [31:0]   rd_refill,
	output logic [31:0]   rd_left
);

	logic [31:0]           left_mem_q   [SLOT_COUNT];
	logic [31:0]           refill_mem_q [SLOT_COUNT];
	logic [SLOT_COUNT-1:0] valid_q;
	logic [31:0]           clr_refill_q;
	logic [31:0]           rd_left_q;
	logic [31:0]           rd_refill_q;
	logic                  rd_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q      <= '0;
			clr_refill_q <= 32'(tsl_pkg::DEFAULT_LEASE_RST);
			rd_valid_q   <= 1'b0;
		end else begin
			rd_valid_q <= valid_q[raddr];
			if (clr) begin
				valid_q      <= '0;
				clr_refill_q <= clr_refill;
			end else if (we) begin
				valid_q[waddr] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			left_mem_q[waddr]   <= wleft;
			refill_mem_q[waddr] <= wrefill;
		end
		rd_left_q   <= left_mem_q[raddr];
		rd_refill_q <= refill_mem_q[raddr];
	end

	assign rd_left   = rd_valid_q ? rd_left_q : '0;
	assign rd_refill = rd_valid_q ? rd_refill_q : clr_refill_q;

endmodule

// ===== rtl/core/tsl_ctrl.sv =====
// Sequencer with one shared subtractor that walks the lease table per item.
module tsl_ctrl #(
	parameter int SLOT_COUNT = tsl_pkg::SLOT_COUNT_DEF,
	localparam int IW = $clog2(SLOT_COUNT)
) (
	input  logic           clk,
	input  logic           arst_n,
	input  tsl_pkg::cfg_t  cfg,
	input  logic           in_valid,
	input  tsl_pkg::in_t   in_data,
	output logic           in_stall,
	output logic           res_valid,
	output tsl_pkg::out_t  res,
	input  logic           res_free,
	output logic           mem_clr,
	output logic [31:0]    mem_clr_refill,
	output logic           mem_we,
	output logic [IW-1:0]  mem_waddr,
	output logic [31:0]    mem_wrefill,
	output logic [31:0]    mem_wleft,
	output logic [IW-1:0]  mem_raddr,
	input  logic [31:0]    mem_rd_refill,
	input  logic [31:0]    mem_rd_left
);

	typedef enum logic [12:0] {
		S_IDLE      = 13'b0000000000001,
		S_REDUCE    = 13'b0000000000010,
		S_CUR       = 13'b0000000000100,
		S_SRCH      = 13'b0000000001000,
		S_PREV      = 13'b0000000010000,
		S_PRVD      = 13'b0000000100000,
		S_JOIN      = 13'b0000001000000,
		S_JOIND     = 13'b0000010000000,
		S_PKT       = 13'b0000100000000,
		S_PKTD      = 13'b0001000000000,
		S_EMIT_REP  = 13'b0010000000000,
		S_EMIT_JOIN = 13'b0100000000000,
		S_EMIT_RST  = 13'b1000000000000
	} state_t;

	state_t        state_q;
	logic [2:0]    op_q;
	logic [3:0]    cur_q;
	logic [7:0]    req_q;
	logic          lowp_q;
	logic          echo_q;
	logic [31:0]   ka_q;
	logic [31:0]   lease_rep_q;
	logic [3:0]    nfree_q;
	logic [IW-1:0] t_q;
	logic [IW-1:0] chk_q;
	logic [IW-1:0] cnt_q;
	logic          exp_q;
	logic          acc_q;
	logic [7:0]    rst_tgt_q;
	logic          rst_echo_q;

	logic [31:0]   alu_a;
	logic [31:0]   alu_b;
	logic [32:0]   alu_diff;
	logic [IW-1:0] cur_i;
	logic [IW-1:0] prv_i;
	logic [IW-1:0] slot_i;
	logic [IW-1:0] req_i;
	logic          chk_free;
	logic          prv_live;
	logic          join_ok;
	logic [31:0]   join_lease;
	logic          pkt_live;
	logic [31:0]   pkt_left;

	function automatic logic [IW-1:0] nxt(input logic [IW-1:0] x);
		nxt = (x == IW'(SLOT_COUNT - 1)) ? '0 : x + 1'b1;
	endfunction

	assign alu_diff = {1'b0, alu_a} - {1'b0, alu_b};

	assign cur_i  = IW'(cur_q);
	assign prv_i  = (cur_i == '0) ? IW'(SLOT_COUNT - 1) : cur_i - 1'b1;
	assign slot_i = IW'(cur_q);
	assign req_i  = IW'(req_q);

	assign chk_free   = (mem_rd_left == '0) && (8'(chk_q) != 8'(cfg.sync_slot));
	assign prv_live   = (8'(prv_i) != 8'(cfg.sync_slot)) && (mem_rd_left != '0);
	assign join_ok    = (req_q < 8'(SLOT_COUNT)) && (req_q != 8'(cfg.sync_slot))
		&& (mem_rd_left == '0);
	assign join_lease = lowp_q ? cfg.low_power_lease : 32'(cfg.default_lease);
	assign pkt_live   = (8'(cur_q) < 8'(SLOT_COUNT)) && (mem_rd_left != '0);

	always_comb begin
		unique case (op_q)
			tsl_pkg::OP_RESET, tsl_pkg::OP_DISCONNECT: pkt_left = '0;
			tsl_pkg::OP_KEEPALIVE: pkt_left = (ka_q != '0) ? ka_q : tsl_pkg::KEEPALIVE_FALLBACK;
			default: pkt_left = alu_diff[32] ? mem_rd_refill : mem_rd_left;
		endcase
	end

	assign in_stall       = (state_q != S_IDLE);
	assign mem_clr_refill = 32'(cfg.default_lease);

	always_comb begin
		mem_clr     = 1'b0;
		mem_we      = 1'b0;
		mem_waddr   = '0;
		mem_wrefill = '0;
		mem_wleft   = '0;
		mem_raddr   = '0;
		alu_a       = '0;
		alu_b       = '0;
		res_valid   = 1'b0;
		res         = '0;
		unique case (state_q)
			S_IDLE: begin
				mem_clr = in_valid && (in_data.operation == tsl_pkg::OP_CLEAR);
			end
			S_REDUCE: begin
				alu_a     = 32'(cur_q);
				alu_b     = 32'(SLOT_COUNT);
				mem_raddr = cur_i;
			end
			S_CUR: mem_raddr = nxt(cur_i);
			S_SRCH: mem_raddr = t_q;
			S_PREV: mem_raddr = prv_i;
			S_PRVD: begin
				alu_a       = mem_rd_left;
				alu_b       = 32'd1;
				mem_we      = prv_live;
				mem_waddr   = prv_i;
				mem_wrefill = mem_rd_refill;
				mem_wleft   = alu_diff[31:0];
			end
			S_JOIN: mem_raddr = req_i;
			S_JOIND: begin
				mem_we      = join_ok;
				mem_waddr   = req_i;
				mem_wrefill = join_lease;
				mem_wleft   = join_lease;
			end
			S_PKT: mem_raddr = slot_i;
			S_PKTD: begin
				alu_a       = mem_rd_left;
				alu_b       = mem_rd_refill;
				mem_we      = pkt_live;
				mem_waddr   = slot_i;
				mem_wrefill = mem_rd_refill;
				mem_wleft   = pkt_left;
			end
			S_EMIT_REP: begin
				res_valid       = res_free;
				res.kind        = tsl_pkg::KIND_SYNC;
				res.target_slot = 8'(cur_q);
				res.lease_left  = lease_rep_q;
				res.next_free   = nfree_q;
				res.last        = !exp_q;
			end
			S_EMIT_JOIN: begin
				res_valid       = res_free;
				res.kind        = tsl_pkg::KIND_JOIN;
				res.target_slot = req_q;
				res.accepted    = acc_q;
				res.last        = 1'b1;
			end
			S_EMIT_RST: begin
				res_valid       = res_free;
				res.kind        = tsl_pkg::KIND_RESET;
				res.target_slot = rst_tgt_q;
				res.echo_flag   = rst_echo_q;
				res.last        = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						unique case (in_data.operation)
							tsl_pkg::OP_TICK: state_q <= S_REDUCE;
							tsl_pkg::OP_JOIN: state_q <= S_JOIN;
							tsl_pkg::OP_DATA, tsl_pkg::OP_RESET, tsl_pkg::OP_DISCONNECT,
							tsl_pkg::OP_KEEPALIVE: state_q <= S_PKT;
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_REDUCE: if (alu_diff[32]) state_q <= S_CUR;
				S_CUR: state_q <= (SLOT_COUNT > 1) ? S_SRCH : S_PREV;
				S_SRCH: if (chk_free || cnt_q == '0) state_q <= S_PREV;
				S_PREV: state_q <= S_PRVD;
				S_PRVD: state_q <= S_EMIT_REP;
				S_JOIN: state_q <= S_JOIND;
				S_JOIND: state_q <= S_EMIT_JOIN;
				S_PKT: state_q <= S_PKTD;
				S_PKTD: begin
					if (pkt_live && op_q == tsl_pkg::OP_RESET && !echo_q) begin
						state_q <= S_EMIT_RST;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_EMIT_REP: if (res_free) state_q <= exp_q ? S_EMIT_RST : S_IDLE;
				S_EMIT_JOIN: if (res_free) state_q <= S_IDLE;
				S_EMIT_RST: if (res_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				op_q   <= in_data.operation;
				cur_q  <= in_data.slot;
				req_q  <= in_data.requested_slot;
				lowp_q <= in_data.low_power;
				echo_q <= in_data.is_echo;
				ka_q   <= in_data.keepalive_lease;
			end
			S_REDUCE: if (!alu_diff[32]) cur_q <= alu_diff[3:0];
			S_CUR: begin
				lease_rep_q <= mem_rd_left;
				nfree_q     <= cfg.sync_slot;
				chk_q       <= nxt(cur_i);
				t_q         <= nxt(nxt(cur_i));
				cnt_q       <= IW'(SLOT_COUNT - 2);
			end
			S_SRCH: begin
				if (chk_free) begin
					nfree_q <= 4'(chk_q);
				end else if (cnt_q != '0) begin
					chk_q <= t_q;
					t_q   <= nxt(t_q);
					cnt_q <= cnt_q - 1'b1;
				end
			end
			S_PRVD: begin
				exp_q      <= prv_live && (alu_diff[31:0] == '0);
				rst_tgt_q  <= 8'(prv_i);
				rst_echo_q <= 1'b0;
			end
			S_JOIND: acc_q <= join_ok;
			S_PKTD: begin
				rst_tgt_q  <= 8'(cur_q);
				rst_echo_q <= 1'b1;
			end
			default: ;
		endcase
	end

endmodule
